// ----- hw/rtl/dpha_pkg.sv -----
// dpha_pkg: constants, codes, types and helper functions of the dual-pool handle allocator.
// No dependencies; every other file of the block uses this package.

package dpha_pkg;

  localparam int SOCKETS     = 256;
  localparam int ID_LIMIT    = 256;
  // Only ids below ID_LIMIT are ever handed out, so higher entries stay clear.
  localparam int POOL_USABLE = (SOCKETS < ID_LIMIT) ? SOCKETS : ID_LIMIT;

  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int NUM_WORDS   = (POOL_USABLE + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ID_W        = $clog2(ID_LIMIT);

  localparam int MODE_W      = 2;
  localparam int HANDLE_W    = 9;
  localparam int STATUS_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC_CLIENT   = 2'd0,
    MODE_ALLOC_SERVER   = 2'd1,
    MODE_RELEASE_CLIENT = 2'd2,
    MODE_RELEASE_SERVER = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2
  } status_t;

  typedef logic [WORD_W-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Bits of word w that lie beyond the usable pool; treated as always taken.
  function automatic word_t pad_mask(input int unsigned w);
    word_t m;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (w * WORD_W + j >= POOL_USABLE) begin
        m[j] = 1'b1;
      end
    end
    return m;
  endfunction

  // Lowest clear bit of a word (0 if none).
  function automatic logic [BIT_W-1:0] first_zero(input word_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!v[j]) begin
        r = BIT_W'(j);
      end
    end
    return r;
  endfunction

  // Lowest word that is not full (0 if none).
  function automatic logic [WORD_IDX_W-1:0] first_open_word(input logic [NUM_WORDS-1:0] full);
    logic [WORD_IDX_W-1:0] r;
    r = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (!full[w]) begin
        r = WORD_IDX_W'(w);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/dpha_ifs.sv -----
// dpha_req_if and dpha_rsp_if: valid/ready channels of the handle allocator.
// Depends on dpha_pkg for field widths.

interface dpha_req_if;
  logic                         valid;
  logic                         ready;
  logic [dpha_pkg::MODE_W-1:0]   mode;
  logic [dpha_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, mode, handle, input ready);
  modport sink   (input valid, mode, handle, output ready);
endinterface

interface dpha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dpha_pkg::HANDLE_W-1:0] handle_out;
  logic [dpha_pkg::STATUS_W-1:0] status;

  modport source (output valid, handle_out, status, input ready);
  modport sink   (input valid, handle_out, status, output ready);
endinterface

// ----- hw/rtl/dpha_datapath.sv -----
// dpha_datapath: request register, both occupancy bitmaps, two-step free search, result register.
// Depends on dpha_pkg; driven by dpha_ctrl through dp_cmd_t.

module dpha_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dpha_pkg::dp_cmd_t             cmd,
  input  logic [dpha_pkg::MODE_W-1:0]   in_mode,
  input  logic [dpha_pkg::HANDLE_W-1:0] in_handle,
  output logic [dpha_pkg::HANDLE_W-1:0] handle_out,
  output logic [dpha_pkg::STATUS_W-1:0] status
);

  dpha_pkg::mode_t                       req_mode;
  logic [dpha_pkg::HANDLE_W-1:0]         req_handle;
  dpha_pkg::word_t                       client_words [dpha_pkg::NUM_WORDS];
  dpha_pkg::word_t                       server_words [dpha_pkg::NUM_WORDS];
  logic [dpha_pkg::WORD_IDX_W-1:0]       word_sel;
  logic                                  any_free;

  logic [dpha_pkg::NUM_WORDS-1:0]        word_full;
  dpha_pkg::word_t                       pick_word;
  logic [dpha_pkg::BIT_W-1:0]            pick_bit;
  logic [dpha_pkg::ID_W-1:0]             alloc_id;
  logic [dpha_pkg::ID_W-1:0]             rel_idx;
  logic [dpha_pkg::WORD_IDX_W-1:0]       rel_word;
  logic [dpha_pkg::BIT_W-1:0]            rel_bit;
  logic                                  rel_in_pool;
  logic                                  is_alloc;
  logic                                  is_server;

  assign is_alloc  = (req_mode == dpha_pkg::MODE_ALLOC_CLIENT) ||
                     (req_mode == dpha_pkg::MODE_ALLOC_SERVER);
  assign is_server = req_mode[0];

  // Step one: per-word full flags of the chosen pool.
  always_comb begin
    for (int w = 0; w < dpha_pkg::NUM_WORDS; w++) begin
      word_full[w] = &((is_server ? server_words[w] : client_words[w]) |
                       dpha_pkg::pad_mask(w));
    end
  end

  // Step two: lowest clear bit in the word picked by step one.
  assign pick_word = (is_server ? server_words[word_sel] : client_words[word_sel]) |
                     dpha_pkg::pad_mask(32'(word_sel));
  assign pick_bit  = dpha_pkg::first_zero(pick_word);
  assign alloc_id  = dpha_pkg::ID_W'({word_sel, pick_bit});

  assign rel_idx     = req_handle[dpha_pkg::HANDLE_W-1:1];
  assign rel_word    = dpha_pkg::WORD_IDX_W'(rel_idx >> dpha_pkg::BIT_W);
  assign rel_bit     = rel_idx[dpha_pkg::BIT_W-1:0];
  assign rel_in_pool = (int'(rel_idx) < dpha_pkg::POOL_USABLE);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode   <= dpha_pkg::mode_t'(in_mode);
      req_handle <= in_handle;
    end
    if (cmd.scan) begin
      word_sel <= dpha_pkg::first_open_word(word_full);
      any_free <= ~&word_full;
    end
    if (cmd.commit) begin
      if (is_alloc && any_free) begin
        handle_out <= {alloc_id, is_server};
        status     <= dpha_pkg::ST_ALLOCATED;
      end else if (is_alloc) begin
        handle_out <= '0;
        status     <= dpha_pkg::ST_FULL;
      end else begin
        handle_out <= '0;
        status     <= dpha_pkg::ST_RELEASED;
      end
    end
  end

  // Bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < dpha_pkg::NUM_WORDS; w++) begin
        client_words[w] <= '0;
        server_words[w] <= '0;
      end
    end else if (cmd.commit) begin
      if (is_alloc && any_free) begin
        if (is_server) begin
          server_words[word_sel][pick_bit] <= 1'b1;
        end else begin
          client_words[word_sel][pick_bit] <= 1'b1;
        end
      end else if (!is_alloc && rel_in_pool) begin
        if (is_server) begin
          server_words[rel_word][rel_bit] <= 1'b0;
        end else begin
          client_words[rel_word][rel_bit] <= 1'b0;
        end
      end
    end
  end

  // Entries beyond the usable pool are never marked.
  a_pad_clear: assert property (@(posedge clk) disable iff (rst)
    ((client_words[dpha_pkg::NUM_WORDS-1] | server_words[dpha_pkg::NUM_WORDS-1]) &
     dpha_pkg::pad_mask(dpha_pkg::NUM_WORDS-1)) == '0)
    else $error("padding bit set in bitmap");

  // An allocation only ever takes an entry that is free.
  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_alloc && any_free) |-> !pick_word[pick_bit])
    else $error("allocation picked a taken entry");

  // A client release leaves its entry clear.
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !is_alloc && rel_in_pool && !is_server)
      |=> !client_words[$past(rel_word)][$past(rel_bit)])
    else $error("client release did not clear entry");

endmodule

// ----- hw/rtl/dpha_ctrl.sv -----
// dpha_ctrl: sequencer of the handle allocator and owner of the result valid flag.
// Depends on dpha_pkg for dp_cmd_t.

module dpha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dpha_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  assign cmd.load_req = in_valid && in_ready;
  assign cmd.scan     = (state == S_SCAN);
  assign cmd.commit   = (state == S_PICK) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (slot_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A committed result is always presented next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // An accepted item closes the input until it is done.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> (state == S_SCAN) && !in_ready)
    else $error("input open while item in flight");

  // The result register is never overwritten while still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

// ----- hw/rtl/dual_pool_handle_allocator.sv -----
// dual_pool_handle_allocator: top level, joins dpha_ctrl and dpha_datapath to the channels.
// Depends on dpha_pkg, dpha_ifs, dpha_ctrl, dpha_datapath.
//
//   channel  dir  fields              meaning
//   req      in   mode, handle        allocate client/server, release client/server
//   rsp      out  handle_out, status  allocated handle (or 0), allocated/full/released
//
// Each item passes through accept, word scan (per-word full flags of the chosen
// pool, 32 bits a word), then bit pick and commit (lowest clear bit of that word).
// The search over the bitmap is two-step, and one item is in flight at a time.
// Commit waits while the result register still holds an item not taken by rsp, and
// no new item is accepted during that wait. The input reopens after commit;
// synchronous reset clears both bitmaps at once.

module dual_pool_handle_allocator (
  input  logic       clk,
  input  logic       rst,
  dpha_req_if.sink   req,
  dpha_rsp_if.source rsp
);

  dpha_pkg::dp_cmd_t cmd;

  // Controller: sequences accept, scan and commit, and holds rsp.valid.
  dpha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath: bitmaps, search and the result register feeding rsp.
  dpha_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mode    (req.mode),
    .in_handle  (req.handle),
    .handle_out (rsp.handle_out),
    .status     (rsp.status)
  );

endmodule
